FILE: sv/http_header_syntax_checker_macros.svh
// assertion macros shared by the header checker modules
`ifndef HTTP_HEADER_SYNTAX_CHECKER_MACROS_SVH
`define HTTP_HEADER_SYNTAX_CHECKER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define HHSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hhsc assertion failed");

// next-cycle implication, disabled while reset is high
`define HHSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hhsc assertion failed");

`endif

FILE: sv/hhsc_pkg.sv
// shared types, constants and text tables of the http header checker
`timescale 1ns / 1ps

package hhsc_pkg;

   // saturation limits and counter widths
   localparam int URI_MAX    = 4095;
   localparam int HEADER_MAX = 255;
   localparam int URI_CW     = $clog2(URI_MAX + 1);
   localparam int HDR_CW     = $clog2(HEADER_MAX + 1);

   // byte queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_FIVE  = 8'h35;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // token positions
   localparam logic [3:0] VER_DIGIT_POS = 4'd7;
   localparam logic [3:0] VER_LEN       = 4'd8;
   localparam logic [3:0] STATUS_LEN    = 4'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_METHOD,
      PH_URI,
      PH_RVER,
      PH_SVER,
      PH_STATUS,
      PH_REASON,
      PH_HEADER
   } phase_type;

   typedef enum logic [1:0] {
      VD_OK,
      VD_BAD_START,
      VD_BAD_HEADER,
      VD_NO_BLANK
   } verdict_type;

   typedef enum logic [1:0] {
      MT_GET,
      MT_POST,
      MT_CONNECT,
      MT_NONE
   } method_type;

   typedef struct packed {
      logic       is_space;
      logic       is_cr;
      logic       is_colon;
      logic       is_digit;
      logic       is_status_lead;
      logic       is_zero;
      logic       is_minor;
      logic [3:0] digit;
   } byte_class_type;

   typedef struct packed {
      logic [7:0]     data_byte;
      logic           is_request;
      logic           first_of_message;
      logic           last_of_message;
      byte_class_type cls;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [3:0] method_len(input logic [1:0] idx);
      logic [3:0] len;
      case (idx)
         MT_GET:  len = 4'd3;
         MT_POST: len = 4'd4;
         default: len = 4'd7;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] method_char(input logic [1:0] idx, input logic [2:0] pos);
      logic [55:0] text;
      logic [7:0]  ch;
      case (idx)
         MT_GET:  text = {"GET", 32'd0};
         MT_POST: text = {"POST", 24'd0};
         default: text = "CONNECT";
      endcase
      case (pos)
         3'd0:    ch = text[55:48];
         3'd1:    ch = text[47:40];
         3'd2:    ch = text[39:32];
         3'd3:    ch = text[31:24];
         3'd4:    ch = text[23:16];
         3'd5:    ch = text[15:8];
         3'd6:    ch = text[7:0];
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] ver_char(input logic [2:0] pos);
      logic [55:0] text;
      logic [7:0]  ch;
      text = "HTTP/1.";
      case (pos)
         3'd0:    ch = text[55:48];
         3'd1:    ch = text[47:40];
         3'd2:    ch = text[39:32];
         3'd3:    ch = text[31:24];
         3'd4:    ch = text[23:16];
         3'd5:    ch = text[15:8];
         3'd6:    ch = text[7:0];
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: sv/http_header_syntax_checker.sv
// top level of the http/1.x message header syntax checker
`timescale 1ns / 1ps

//  channel | direction | handshake            | beat
//  req     | in        | req_valid, req_stall | one message byte with start/end marks
//  rsp     | out       | rsp_valid, rsp_stall | one verdict with start line summary
//
//  takes one byte per cycle while the queue is not full; the per-byte parser in the back end sets that rate
//  a verdict's deciding byte is registered in the queue, then the verdict goes to the verdict register behind rsp_valid
//  synchronous reset empties the queue and leaves the parser waiting for a first byte
//  rsp_stall on a waiting verdict holds the verdict register and stops the queue draining
//  req_stall rises only once the four-beat queue is full

module http_header_syntax_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_request,
   input  logic        req_first_of_message,
   input  logic        req_last_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_verdict,
   output logic [1:0]  rsp_method,
   output logic        rsp_minor_version,
   output logic [9:0]  rsp_status_code,
   output logic [11:0] rsp_uri_length,
   output logic [7:0]  rsp_header_count,
   output logic        rsp_was_request
);
   import hhsc_pkg::*;

   // front to queue
   logic             push;
   item_type         push_item;
   // queue to back
   item_type         head_item;
   queue_status_type q_status;
   logic             pop;

   // byte classification and input handshake
   hhsc_front u_front (
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_is_request       (req_is_request),
      .req_first_of_message (req_first_of_message),
      .req_last_of_message  (req_last_of_message),
      .q_status             (q_status),
      .push_o               (push),
      .item_o               (push_item)
   );

   // decouples byte intake from verdict stalls
   hhsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_i   (push),
      .item_i   (push_item),
      .pop_i    (pop),
      .item_o   (head_item),
      .status_o (q_status)
   );

   // parser and verdict register
   hhsc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .item_i            (head_item),
      .q_status          (q_status),
      .pop_o             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_verdict       (rsp_verdict),
      .rsp_method        (rsp_method),
      .rsp_minor_version (rsp_minor_version),
      .rsp_status_code   (rsp_status_code),
      .rsp_uri_length    (rsp_uri_length),
      .rsp_header_count  (rsp_header_count),
      .rsp_was_request   (rsp_was_request)
   );

endmodule

FILE: sv/hhsc_front.sv
// front end: accepts message bytes, classifies them and pushes them into the queue
`timescale 1ns / 1ps

module hhsc_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_is_request,
   input  logic                      req_first_of_message,
   input  logic                      req_last_of_message,
   input  hhsc_pkg::queue_status_type q_status,
   output logic                      push_o,
   output hhsc_pkg::item_type        item_o
);
   import hhsc_pkg::*;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type c;
      c.is_space       = (b == CH_SPACE);
      c.is_cr          = (b == CH_CR);
      c.is_colon       = (b == CH_COLON);
      c.is_digit       = (b >= CH_ZERO) && (b <= CH_NINE);
      c.is_status_lead = (b >= CH_ONE) && (b <= CH_FIVE);
      c.is_zero        = (b == CH_ZERO);
      c.is_minor       = (b == CH_ZERO) || (b == CH_ONE);
      c.digit          = 4'(b - CH_ZERO);
      return c;
   endfunction

   // stall only on a full queue
   assign req_stall = q_status.full;
   assign push_o    = req_valid && !q_status.full;

   always_comb begin
      item_o.data_byte        = req_data_byte;
      item_o.is_request       = req_is_request;
      item_o.first_of_message = req_first_of_message;
      item_o.last_of_message  = req_last_of_message;
      item_o.cls              = classify(req_data_byte);
   end

endmodule

FILE: sv/hhsc_queue.sv
// short fifo of classified bytes between front and back
`timescale 1ns / 1ps
`include "http_header_syntax_checker_macros.svh"

module hhsc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_i,
   input  hhsc_pkg::item_type         item_i,
   input  logic                       pop_i,
   output hhsc_pkg::item_type         item_o,
   output hhsc_pkg::queue_status_type status_o
);
   import hhsc_pkg::*;

   item_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push_i) - QCNT_W'(pop_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= item_i;
      end
   end

   assign item_o         = mem_ff[rd_ptr_ff];
   assign status_o.empty = (count_ff == '0);
   assign status_o.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));

   `HHSC_ASSERT_IMPL(a_push_not_full, clock, reset, push_i, !status_o.full)
   `HHSC_ASSERT_IMPL(a_pop_not_empty, clock, reset, pop_i, !status_o.empty)
   `HHSC_ASSERT_NEXT(a_pop_drains, clock, reset, pop_i && !push_i, count_ff == $past(count_ff) - 1'b1)

endmodule

FILE: sv/hhsc_back.sv
// back end: per-byte parser state machine and result register
`timescale 1ns / 1ps
`include "http_header_syntax_checker_macros.svh"

module hhsc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  hhsc_pkg::item_type         item_i,
   input  hhsc_pkg::queue_status_type q_status,
   output logic                       pop_o,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_verdict,
   output logic [1:0]                 rsp_method,
   output logic                       rsp_minor_version,
   output logic [9:0]                 rsp_status_code,
   output logic [11:0]                rsp_uri_length,
   output logic [7:0]                 rsp_header_count,
   output logic                       rsp_was_request
);
   import hhsc_pkg::*;

   // parser state
   phase_type         phase_ff, phase_in;
   logic [3:0]        tpos_ff, tpos_in;
   logic [2:0]        cand_ff, cand_in;
   logic              minor_ff, minor_in;
   logic [9:0]        status_ff, status_in;
   logic [URI_CW-1:0] uri_ff, uri_in;
   logic [HDR_CW-1:0] hdr_ff, hdr_in;
   logic              colon_ff, colon_in;
   logic              lbc_ff, lbc_in;
   logic              skip_ff, skip_in;
   logic              req_ff, req_in;
   logic              finished_ff, finished_in;

   // state as seen by this byte, after a message start
   phase_type         c_phase;
   logic [3:0]        c_tpos;
   logic [2:0]        c_cand;
   logic              c_minor;
   logic [9:0]        c_status;
   logic [URI_CW-1:0] c_uri;
   logic [HDR_CW-1:0] c_hdr;
   logic              c_colon;
   logic              c_lbc;
   logic              c_skip;
   logic              c_req;
   logic              c_finished;

   logic              ver_ok;
   logic [2:0]        sel;
   logic              code_valid;
   verdict_type       code;
   logic              out_free;
   logic              load;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   verdict_type       verdict_ff, verdict_in;
   method_type        method_ff, method_in;
   logic              minor_out_ff, minor_out_in;
   logic [9:0]        status_out_ff, status_out_in;
   logic [11:0]       uri_out_ff, uri_out_in;
   logic [7:0]        hdr_out_ff, hdr_out_in;
   logic              req_out_ff, req_out_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop_o    = !q_status.empty && out_free;
   assign load     = pop_o && code_valid;

   // message start override
   always_comb begin
      c_phase    = phase_ff;
      c_tpos     = tpos_ff;
      c_cand     = cand_ff;
      c_minor    = minor_ff;
      c_status   = status_ff;
      c_uri      = uri_ff;
      c_hdr      = hdr_ff;
      c_colon    = colon_ff;
      c_lbc      = lbc_ff;
      c_skip     = skip_ff;
      c_req      = req_ff;
      c_finished = finished_ff;
      if (item_i.first_of_message) begin
         c_phase    = item_i.is_request ? PH_METHOD : PH_SVER;
         c_tpos     = '0;
         c_cand     = 3'b111;
         c_minor    = 1'b0;
         c_status   = '0;
         c_uri      = '0;
         c_hdr      = '0;
         c_colon    = 1'b0;
         c_lbc      = 1'b0;
         c_skip     = 1'b0;
         c_req      = item_i.is_request;
         c_finished = 1'b0;
      end
   end

   // version token byte check
   always_comb begin
      if (c_tpos < VER_DIGIT_POS) begin
         ver_ok = (item_i.data_byte == ver_char(c_tpos[2:0]));
      end else if (c_tpos == VER_DIGIT_POS) begin
         ver_ok = item_i.cls.is_minor;
      end else begin
         ver_ok = 1'b0;
      end
   end

   // next state
   always_comb begin
      phase_in    = c_phase;
      tpos_in     = c_tpos;
      cand_in     = c_cand;
      minor_in    = c_minor;
      status_in   = c_status;
      uri_in      = c_uri;
      hdr_in      = c_hdr;
      colon_in    = c_colon;
      lbc_in      = c_lbc;
      skip_in     = c_skip;
      req_in      = c_req;
      finished_in = c_finished;
      sel         = '0;
      code_valid  = 1'b0;
      code        = VD_OK;
      if (!c_finished) begin
         if (c_skip) begin
            skip_in = 1'b0;
         end else begin
            case (c_phase)
               PH_METHOD: begin
                  if (item_i.cls.is_space) begin
                     for (int i = 0; i < 3; i++) begin
                        sel[i] = c_cand[i] && (method_len(2'(i)) == c_tpos);
                     end
                  end else begin
                     for (int i = 0; i < 3; i++) begin
                        sel[i] = c_cand[i] && (c_tpos < method_len(2'(i)))
                                 && (item_i.data_byte == method_char(2'(i), c_tpos[2:0]));
                     end
                  end
                  if (sel == '0) begin
                     code_valid = 1'b1;
                     code       = VD_BAD_START;
                  end else if (item_i.cls.is_space) begin
                     cand_in  = sel;
                     phase_in = PH_URI;
                     tpos_in  = '0;
                  end else begin
                     cand_in = sel;
                     tpos_in = c_tpos + 1'b1;
                  end
               end
               PH_URI: begin
                  if (item_i.cls.is_cr || (item_i.cls.is_space && c_uri == '0)) begin
                     code_valid = 1'b1;
                     code       = VD_BAD_START;
                  end else if (item_i.cls.is_space) begin
                     phase_in = PH_RVER;
                     tpos_in  = '0;
                  end else if (c_uri < URI_CW'(URI_MAX)) begin
                     uri_in = c_uri + 1'b1;
                  end
               end
               PH_RVER: begin
                  if (item_i.cls.is_cr) begin
                     if (c_tpos != VER_LEN) begin
                        code_valid = 1'b1;
                        code       = VD_BAD_START;
                     end else begin
                        phase_in = PH_HEADER;
                        colon_in = 1'b0;
                        lbc_in   = 1'b0;
                        skip_in  = 1'b1;
                     end
                  end else if (!ver_ok) begin
                     code_valid = 1'b1;
                     code       = VD_BAD_START;
                  end else begin
                     tpos_in = c_tpos + 1'b1;
                     if (c_tpos == VER_DIGIT_POS) begin
                        minor_in = item_i.data_byte[0];
                     end
                  end
               end
               PH_SVER: begin
                  if (item_i.cls.is_space) begin
                     if (c_tpos != VER_LEN) begin
                        code_valid = 1'b1;
                        code       = VD_BAD_START;
                     end else begin
                        phase_in = PH_STATUS;
                        tpos_in  = '0;
                     end
                  end else if (item_i.cls.is_cr || !ver_ok) begin
                     code_valid = 1'b1;
                     code       = VD_BAD_START;
                  end else begin
                     tpos_in = c_tpos + 1'b1;
                     if (c_tpos == VER_DIGIT_POS) begin
                        minor_in = item_i.data_byte[0];
                     end
                  end
               end
               PH_STATUS: begin
                  if (item_i.cls.is_space) begin
                     if (c_tpos != STATUS_LEN) begin
                        code_valid = 1'b1;
                        code       = VD_BAD_START;
                     end else begin
                        phase_in = PH_REASON;
                     end
                  end else begin
                     case (c_tpos)
                        4'd0: begin
                           if (item_i.cls.is_status_lead) begin
                              status_in = (10'(item_i.cls.digit) << 6)
                                        + (10'(item_i.cls.digit) << 5)
                                        + (10'(item_i.cls.digit) << 2);
                              tpos_in   = c_tpos + 1'b1;
                           end else begin
                              code_valid = 1'b1;
                              code       = VD_BAD_START;
                           end
                        end
                        4'd1: begin
                           if (item_i.cls.is_zero) begin
                              tpos_in = c_tpos + 1'b1;
                           end else begin
                              code_valid = 1'b1;
                              code       = VD_BAD_START;
                           end
                        end
                        4'd2: begin
                           if (item_i.cls.is_digit) begin
                              status_in = c_status + 10'(item_i.cls.digit);
                              tpos_in   = c_tpos + 1'b1;
                           end else begin
                              code_valid = 1'b1;
                              code       = VD_BAD_START;
                           end
                        end
                        default: begin
                           code_valid = 1'b1;
                           code       = VD_BAD_START;
                        end
                     endcase
                  end
               end
               PH_REASON: begin
                  if (item_i.cls.is_cr) begin
                     phase_in = PH_HEADER;
                     colon_in = 1'b0;
                     lbc_in   = 1'b0;
                     skip_in  = 1'b1;
                  end
               end
               default: begin
                  if (item_i.cls.is_cr) begin
                     if (!c_lbc) begin
                        code_valid = 1'b1;
                        code       = VD_OK;
                     end else if (!c_colon) begin
                        code_valid = 1'b1;
                        code       = VD_BAD_HEADER;
                     end else begin
                        if (c_hdr < HDR_CW'(HEADER_MAX)) begin
                           hdr_in = c_hdr + 1'b1;
                        end
                        phase_in = PH_HEADER;
                        colon_in = 1'b0;
                        lbc_in   = 1'b0;
                        skip_in  = 1'b1;
                     end
                  end else if (item_i.cls.is_colon && !c_colon && !c_lbc) begin
                     code_valid = 1'b1;
                     code       = VD_BAD_HEADER;
                  end else begin
                     if (item_i.cls.is_colon) begin
                        colon_in = 1'b1;
                     end
                     lbc_in = 1'b1;
                  end
               end
            endcase
         end
         if (!code_valid && item_i.last_of_message) begin
            code_valid = 1'b1;
            code       = VD_NO_BLANK;
         end
      end
      if (code_valid) begin
         finished_in = 1'b1;
      end
   end

   // verdict fields
   always_comb begin
      verdict_in = code;
      method_in  = MT_NONE;
      if (req_in && (phase_in inside {PH_URI, PH_RVER, PH_HEADER})) begin
         if (cand_in[0]) begin
            method_in = MT_GET;
         end else if (cand_in[1]) begin
            method_in = MT_POST;
         end else if (cand_in[2]) begin
            method_in = MT_CONNECT;
         end
      end
      if (req_in) begin
         minor_out_in = (phase_in == PH_HEADER) && minor_in;
      end else begin
         minor_out_in = (phase_in inside {PH_STATUS, PH_REASON, PH_HEADER}) && minor_in;
      end
      status_out_in = (!req_in && (phase_in inside {PH_REASON, PH_HEADER})) ? status_in : '0;
      uri_out_in    = req_in ? 12'(uri_in) : '0;
      hdr_out_in    = 8'(hdr_in);
      req_out_in    = req_in;
      rsp_valid_in  = out_free ? load : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tpos_ff     <= '0;
         cand_ff     <= 3'b111;
         minor_ff    <= 1'b0;
         status_ff   <= '0;
         uri_ff      <= '0;
         hdr_ff      <= '0;
         colon_ff    <= 1'b0;
         lbc_ff      <= 1'b0;
         skip_ff     <= 1'b0;
         req_ff      <= 1'b0;
         finished_ff <= 1'b1;
      end else if (pop_o) begin
         phase_ff    <= phase_in;
         tpos_ff     <= tpos_in;
         cand_ff     <= cand_in;
         minor_ff    <= minor_in;
         status_ff   <= status_in;
         uri_ff      <= uri_in;
         hdr_ff      <= hdr_in;
         colon_ff    <= colon_in;
         lbc_ff      <= lbc_in;
         skip_ff     <= skip_in;
         req_ff      <= req_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff    <= verdict_in;
         method_ff     <= method_in;
         minor_out_ff  <= minor_out_in;
         status_out_ff <= status_out_in;
         uri_out_ff    <= uri_out_in;
         hdr_out_ff    <= hdr_out_in;
         req_out_ff    <= req_out_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict       = verdict_ff;
   assign rsp_method        = method_ff;
   assign rsp_minor_version = minor_out_ff;
   assign rsp_status_code   = status_out_ff;
   assign rsp_uri_length    = uri_out_ff;
   assign rsp_header_count  = hdr_out_ff;
   assign rsp_was_request   = req_out_ff;

   `HHSC_ASSERT_NEXT(a_verdict_ends_message, clock, reset, load, finished_ff)
   `HHSC_ASSERT_NEXT(a_verdict_shown, clock, reset, load, rsp_valid_ff)
   `HHSC_ASSERT_NEXT(a_verdict_held, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(verdict_ff))

endmodule

FILE: tb/tb_top.sv
// self-checking testbench of the http header syntax checker: byte stream in, verdicts checked
`timescale 1ns / 1ps

module tb_top;
   import hhsc_pkg::*;

   // run bounds, all in clock cycles or bytes
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_LIMIT  = 3000;
   localparam int TAIL_CYCLES  = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int TOTAL_BYTES  = 1650;

   // stand-in for cr inside directed message text
   localparam logic [7:0] CR_MARK = 8'h7C;
   localparam logic [7:0] CH_LF   = 8'h0A;

   typedef struct {
      verdict_type verdict;
      method_type  method;
      logic        minor;
      logic [9:0]  status;
      logic [11:0] uri_len;
      logic [7:0]  hdr_cnt;
      logic        was_req;
   } header_verdict_type;

   typedef enum {MG_FLIP, MG_SPECIAL, MG_DROP, MG_EXTRA, MG_CUT} mangle_kind_type;
   typedef enum {SM_NONE, SM_LIGHT, SM_HEAVY} stall_mode_type;

   // parser copy plus the queue of verdicts still owed by the block
   class verdict_scoreboard;
      header_verdict_type pending_verdicts[$];
      int                 fails;
      phase_type          stage;
      int                 tok_idx;
      int                 status_acc;
      int                 uri_len;
      int                 hdr_lines;
      logic [2:0]         meth_mask;
      logic               minor_seen;
      bit                 colon_seen;
      bit                 line_started;
      bit                 drop_next;
      bit                 req_msg;
      bit                 idle;
      string              meth_text[3];
      string              ver_text;

      function new();
         meth_text[0] = "GET";
         meth_text[1] = "POST";
         meth_text[2] = "CONNECT";
         ver_text     = "HTTP/1.";
         fails        = 0;
         restart(1'b0);
         stage = PH_IDLE;
         idle  = 1'b1;
      endfunction

      task report(string what);
         fails++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      function void restart(bit req);
         stage        = req ? PH_METHOD : PH_SVER;
         tok_idx      = 0;
         meth_mask    = 3'b111;
         minor_seen   = 1'b0;
         status_acc   = 0;
         uri_len      = 0;
         hdr_lines    = 0;
         colon_seen   = 1'b0;
         line_started = 1'b0;
         drop_next    = 1'b0;
         req_msg      = req;
         idle         = 1'b0;
      endfunction

      function void open_line();
         stage        = PH_HEADER;
         colon_seen   = 1'b0;
         line_started = 1'b0;
         drop_next    = 1'b1;
      endfunction

      function bit match_version(logic [7:0] b);
         if (tok_idx < 7) begin
            if (b != ver_text[tok_idx]) return 1'b0;
         end else if (tok_idx == 7) begin
            if (b != CH_ZERO && b != CH_ONE) return 1'b0;
            minor_seen = b[0];
         end else begin
            return 1'b0;
         end
         tok_idx++;
         return 1'b1;
      endfunction

      // returns 1 when this byte settles the message, with its verdict in v
      function bit consume(input logic [7:0] b, output verdict_type v);
         logic [2:0] sel;
         v = VD_BAD_START;
         sel = 3'b000;
         case (stage)
            PH_METHOD: begin
               if (b == CH_SPACE) begin
                  for (int i = 0; i < 3; i++)
                     if (meth_mask[i] && meth_text[i].len() == tok_idx) sel[i] = 1'b1;
                  if (sel == 3'b000) return 1'b1;
                  meth_mask = sel;
                  stage     = PH_URI;
                  tok_idx   = 0;
                  return 1'b0;
               end
               for (int i = 0; i < 3; i++)
                  if (meth_mask[i] && tok_idx < meth_text[i].len()
                      && b == meth_text[i][tok_idx]) sel[i] = 1'b1;
               if (sel == 3'b000) return 1'b1;
               meth_mask = sel;
               tok_idx++;
               return 1'b0;
            end
            PH_URI: begin
               if (b == CH_CR) return 1'b1;
               if (b == CH_SPACE) begin
                  if (uri_len == 0) return 1'b1;
                  stage   = PH_RVER;
                  tok_idx = 0;
                  return 1'b0;
               end
               if (uri_len < URI_MAX) uri_len++;
               return 1'b0;
            end
            PH_RVER: begin
               if (b == CH_CR) begin
                  if (tok_idx != 8) return 1'b1;
                  open_line();
                  return 1'b0;
               end
               return !match_version(b);
            end
            PH_SVER: begin
               if (b == CH_SPACE) begin
                  if (tok_idx != 8) return 1'b1;
                  stage   = PH_STATUS;
                  tok_idx = 0;
                  return 1'b0;
               end
               if (b == CH_CR) return 1'b1;
               return !match_version(b);
            end
            PH_STATUS: begin
               if (b == CH_SPACE) begin
                  if (tok_idx != 3) return 1'b1;
                  stage = PH_REASON;
                  return 1'b0;
               end
               if (tok_idx == 0) begin
                  if (b < CH_ONE || b > CH_FIVE) return 1'b1;
                  status_acc = int'(b - CH_ZERO) * 100;
               end else if (tok_idx == 1) begin
                  if (b != CH_ZERO) return 1'b1;
               end else if (tok_idx == 2) begin
                  if (b < CH_ZERO || b > CH_NINE) return 1'b1;
                  status_acc = status_acc + int'(b - CH_ZERO);
               end else begin
                  return 1'b1;
               end
               tok_idx++;
               return 1'b0;
            end
            PH_REASON: begin
               if (b == CH_CR) open_line();
               return 1'b0;
            end
            default: begin
               v = VD_BAD_HEADER;
               if (b == CH_CR) begin
                  if (!line_started) begin
                     v = VD_OK;
                     return 1'b1;
                  end
                  if (!colon_seen) return 1'b1;
                  if (hdr_lines < HEADER_MAX) hdr_lines++;
                  open_line();
                  return 1'b0;
               end
               if (b == CH_COLON && !colon_seen) begin
                  if (!line_started) return 1'b1;
                  colon_seen = 1'b1;
               end
               line_started = 1'b1;
               return 1'b0;
            end
         endcase
      endfunction

      function header_verdict_type make_verdict(verdict_type v);
         header_verdict_type r;
         bit meth_ok, ver_ok, stat_ok;
         meth_ok = req_msg && (stage == PH_URI || stage == PH_RVER || stage == PH_HEADER);
         ver_ok  = req_msg ? (stage == PH_HEADER)
                           : (stage == PH_STATUS || stage == PH_REASON || stage == PH_HEADER);
         stat_ok = !req_msg && (stage == PH_REASON || stage == PH_HEADER);
         r.verdict = v;
         r.method  = MT_NONE;
         if (meth_ok) begin
            if (meth_mask[0]) r.method = MT_GET;
            else if (meth_mask[1]) r.method = MT_POST;
            else if (meth_mask[2]) r.method = MT_CONNECT;
         end
         r.minor   = ver_ok ? minor_seen : 1'b0;
         r.status  = stat_ok ? status_acc[9:0] : 10'd0;
         r.uri_len = req_msg ? uri_len[11:0] : 12'd0;
         r.hdr_cnt = hdr_lines[7:0];
         r.was_req = req_msg;
         return r;
      endfunction

      // one accepted input beat
      function void note_byte(logic [7:0] b, bit req, bit is_first, bit is_last);
         verdict_type v;
         bit          settled;
         settled = 1'b0;
         v       = VD_OK;
         if (is_first) restart(req);
         if (idle) return;
         if (drop_next) drop_next = 1'b0;
         else settled = consume(b, v);
         if (!settled && is_last) begin
            settled = 1'b1;
            v       = VD_NO_BLANK;
         end
         if (!settled) return;
         pending_verdicts.push_back(make_verdict(v));
         idle = 1'b1;
      endfunction

      task cmp(string name, logic [11:0] got, logic [11:0] want);
         if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      // one accepted result beat
      task check_verdict(header_verdict_type got);
         header_verdict_type want;
         if (pending_verdicts.size() == 0) begin
            report("verdict with none outstanding");
            return;
         end
         want = pending_verdicts.pop_front();
         cmp("verdict", got.verdict, want.verdict);
         cmp("method", got.method, want.method);
         cmp("minor_version", got.minor, want.minor);
         cmp("status_code", got.status, want.status);
         cmp("uri_length", got.uri_len, want.uri_len);
         cmp("header_count", got.hdr_cnt, want.hdr_cnt);
         cmp("was_request", got.was_req, want.was_req);
      endtask
   endclass

   logic        clock;
   logic        reset                = 1'b1;
   logic        req_valid            = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte        = 8'd0;
   logic        req_is_request       = 1'b0;
   logic        req_first_of_message = 1'b0;
   logic        req_last_of_message  = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall            = 1'b0;
   logic [1:0]  rsp_verdict;
   logic [1:0]  rsp_method;
   logic        rsp_minor_version;
   logic [9:0]  rsp_status_code;
   logic [11:0] rsp_uri_length;
   logic [7:0]  rsp_header_count;
   logic        rsp_was_request;

   verdict_scoreboard sb;
   logic [7:0]        msg[$];     // message text being built
   int                cycle_count = 0;
   int                sent_bytes  = 0;      // input beats accepted so far
   int                burst_left  = 0;
   bit                valid_up    = 1'b0;   // shadow of req_valid for same-step decisions
   bit                gaps_on     = 1'b1;   // sender may idle between bursts
   bit                hold_rsp    = 1'b0;   // asks the receiver for one long hold-off

   http_header_syntax_checker u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_is_request       (req_is_request),
      .req_first_of_message (req_first_of_message),
      .req_last_of_message  (req_last_of_message),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_verdict          (rsp_verdict),
      .rsp_method           (rsp_method),
      .rsp_minor_version    (rsp_minor_version),
      .rsp_status_code      (rsp_status_code),
      .rsp_uri_length       (rsp_uri_length),
      .rsp_header_count     (rsp_header_count),
      .rsp_was_request      (rsp_was_request)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog: a correct run ends far below this
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // result monitor: values read right after the edge are the ones the edge sampled
   always @(posedge clock) begin
      header_verdict_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.verdict = verdict_type'(rsp_verdict);
         got.method  = method_type'(rsp_method);
         got.minor   = rsp_minor_version;
         got.status  = rsp_status_code;
         got.uri_len = rsp_uri_length;
         got.hdr_cnt = rsp_header_count;
         got.was_req = rsp_was_request;
         sb.check_verdict(got);
      end
   end

   // receiver: switches between stall densities, plus one long hold-off on request
   initial begin
      stall_mode_type mode;
      int             mode_left;
      mode      = SM_NONE;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               SM_NONE:  rsp_stall <= 1'b0;
               SM_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               default:  rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // offer one beat, wait for it to be taken, then maybe idle between bursts
   task automatic send_byte(logic [7:0] b, bit req, bit is_first, bit is_last);
      int idle_len;
      req_valid            <= 1'b1;
      valid_up             = 1'b1;
      req_data_byte        <= b;
      req_is_request       <= req;
      req_first_of_message <= is_first;
      req_last_of_message  <= is_last;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_byte(b, req, is_first, is_last);
      sent_bytes++;
      if (gaps_on) begin
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            idle_len   = $urandom_range(1, 9);
            req_valid <= 1'b0;
            valid_up   = 1'b0;
            repeat (idle_len) @(posedge clock);
         end
      end
   endtask

   // sender pause: idle until every owed verdict is in, then let the pipe settle
   task automatic drain();
      int waited;
      waited = 0;
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up   = 1'b0;
      end
      while (sb.pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // is_request only matters on the first byte, so it is noise elsewhere
   task automatic send_message(bit req, bit mark_last);
      for (int i = 0; i < msg.size(); i++)
         send_byte(msg[i], (i == 0) ? req : 1'($urandom_range(0, 1)), i == 0,
                   mark_last && i == msg.size() - 1);
   endtask

   // directed text uses a bar for cr
   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++)
         msg.push_back((s[i] == CR_MARK) ? CH_CR : s[i]);
   endfunction

   task automatic send_text(bit req, string s, bit mark_last);
      msg.delete();
      put_text(s);
      send_message(req, mark_last);
   endtask

   function automatic logic [7:0] pick_byte(bit no_space, bit no_cr, bit no_colon);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while ((no_space && b == CH_SPACE) || (no_cr && b == CH_CR)
             || (no_colon && b == CH_COLON));
      return b;
   endfunction

   // line end; the byte after cr is dropped by the parser, so it is mostly lf
   function automatic void put_eol();
      msg.push_back(CH_CR);
      msg.push_back(($urandom_range(0, 7) == 0) ? pick_byte(1'b0, 1'b0, 1'b0) : CH_LF);
   endfunction

   function automatic void put_version();
      put_text("HTTP/1.");
      msg.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
   endfunction

   // well-formed message with random content, optional trailing body
   function automatic void build_message(bit req, int n_hdr);
      msg.delete();
      if (req) begin
         case ($urandom_range(0, 2))
            0:       put_text("GET");
            1:       put_text("POST");
            default: put_text("CONNECT");
         endcase
         msg.push_back(CH_SPACE);
         repeat ($urandom_range(1, 24)) msg.push_back(pick_byte(1'b1, 1'b1, 1'b0));
         msg.push_back(CH_SPACE);
         put_version();
      end else begin
         put_version();
         msg.push_back(CH_SPACE);
         msg.push_back(CH_ONE + 8'($urandom_range(0, 4)));
         msg.push_back(CH_ZERO);
         msg.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
         msg.push_back(CH_SPACE);
         repeat ($urandom_range(0, 16)) msg.push_back(pick_byte(1'b0, 1'b1, 1'b0));
      end
      put_eol();
      repeat (n_hdr) begin
         repeat ($urandom_range(1, 8)) msg.push_back(pick_byte(1'b0, 1'b1, 1'b1));
         msg.push_back(CH_COLON);
         repeat ($urandom_range(0, 16)) msg.push_back(pick_byte(1'b0, 1'b1, 1'b0));
         put_eol();
      end
      put_eol();
      repeat ($urandom_range(0, 8)) msg.push_back(pick_byte(1'b0, 1'b0, 1'b0));
   endfunction

   // break one spot of the message
   function automatic void mangle();
      int              pos;
      mangle_kind_type kind;
      pos  = $urandom_range(0, msg.size() - 1);
      kind = mangle_kind_type'($urandom_range(0, 4));
      case (kind)
         MG_FLIP: msg[pos] = pick_byte(1'b0, 1'b0, 1'b0);
         MG_SPECIAL: begin
            case ($urandom_range(0, 2))
               0:       msg[pos] = CH_SPACE;
               1:       msg[pos] = CH_CR;
               default: msg[pos] = CH_COLON;
            endcase
         end
         MG_DROP: begin
            msg.delete(pos);
            if (msg.size() == 0) msg.push_back(pick_byte(1'b0, 1'b0, 1'b0));
         end
         MG_EXTRA: msg.insert(pos, pick_byte(1'b0, 1'b0, 1'b0));
         default: while (msg.size() > pos + 1) void'(msg.pop_back());
      endcase
   endfunction

   initial begin
      bit req;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: good messages of every method and both kinds
      send_text(1'b1, "GET /index.html HTTP/1.1|\nHost: a|\n|\n", 1'b1);
      send_text(1'b1, "POST /x HTTP/1.0|\n|\n", 1'b1);
      send_text(1'b1, "CONNECT h:443 HTTP/1.1|\nA:|\n|\n", 1'b1);
      send_text(1'b0, "HTTP/1.1 100 Continue|\n|\n", 1'b1);
      send_text(1'b0, "HTTP/1.0 509 |\nX-a: b:c|\n|\nbody", 1'b1);
      // start line failures, each at the first byte that rules the line out
      send_text(1'b1, "|\n", 1'b1);
      send_text(1'b1, "GETS / HTTP/1.1|\n|\n", 1'b1);
      send_text(1'b1, "CON / HTTP/1.1|\n|\n", 1'b1);
      send_text(1'b1, "GET /a|\n", 1'b1);
      send_text(1'b1, "GET  HTTP/1.1|\n|\n", 1'b1);
      send_text(1'b1, "GET / HTTP/1.2|\n|\n", 1'b1);
      send_text(1'b1, "GET / HTTP/1.1x|\n|\n", 1'b1);
      send_text(1'b0, "HTTP/1.1 600 no|\n|\n", 1'b1);
      send_text(1'b0, "HTTP/1.1 210 no|\n|\n", 1'b1);
      send_text(1'b0, "HTTP/1.1 2000 no|\n|\n", 1'b1);
      send_text(1'b0, "HTTP/1.1|\n", 1'b1);
      // header line failures: no colon, colon as first byte
      send_text(1'b0, "HTTP/1.1 204 x|\nnocolon|\n|\n", 1'b1);
      send_text(1'b1, "GET / HTTP/1.1|\n:empty|\n|\n", 1'b1);
      // byte after cr dropped whatever it holds
      send_text(1'b0, "HTTP/1.1 200 ok|Xa:b|Y|Z", 1'b1);
      // end without blank line, single-byte message, last mark on the deciding cr
      send_text(1'b1, "GET / HTTP/1.1|\nk:v|\n", 1'b1);
      send_text(1'b1, "G", 1'b1);
      send_text(1'b1, "GET / HTTP/1.1|\n|", 1'b1);
      // stray beats while finished, then a message cut off by a new first byte
      send_byte(8'hFF, 1'b1, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0, 1'b0);
      send_text(1'b1, "GET / HTT", 1'b0);
      send_text(1'b0, "HTTP/1.0 404 gone|\n|\n", 1'b1);
      drain();

      // long receiver hold-off while the sender streams without gaps: fills the queue
      gaps_on  = 1'b0;
      hold_rsp = 1'b1;
      repeat (2) begin
         req = $urandom_range(0, 1);
         build_message(req, $urandom_range(2, 5));
         send_message(req, 1'b1);
      end
      gaps_on = 1'b1;
      drain();

      // random: mostly well-formed messages, some broken, some unterminated, some noise
      while (sent_bytes < TOTAL_BYTES) begin
         req = $urandom_range(0, 1);
         build_message(req, $urandom_range(0, 5));
         if ($urandom_range(0, 9) < 3) mangle();
         send_message(req, $urandom_range(0, 9) != 0);
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 4))
               send_byte(pick_byte(1'b0, 1'b0, 1'b0), 1'($urandom_range(0, 1)), 1'b0,
                         1'($urandom_range(0, 1)));
         if ($urandom_range(0, 49) == 0) drain();
      end

      drain();
      if (sb.pending_verdicts.size() != 0)
         sb.report($sformatf("%0d verdicts never arrived", sb.pending_verdicts.size()));
      if (sb.fails == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
